[rtl/smi_pkg.sv]
`default_nettype none

package smi_pkg;

    // sequencer positions, one per waveform segment
    typedef enum logic [4:0] {
        ST_IDLE  = 5'd0,
        ST_START = 5'd1,
        ST_CTRL1 = 5'd2,
        ST_CTRL2 = 5'd3,
        ST_RW    = 5'd4,
        ST_ACKA  = 5'd5,
        ST_ALO   = 5'd6,
        ST_ACKB  = 5'd7,
        ST_AHI   = 5'd8,
        ST_ACKC  = 5'd9,
        ST_DLO   = 5'd10,
        ST_ACKD  = 5'd11,
        ST_DHI   = 5'd12,
        ST_ACKE  = 5'd13,
        ST_RLO   = 5'd14,
        ST_MACK  = 5'd15,
        ST_RHI   = 5'd16,
        ST_MNACK = 5'd17,
        ST_STOP  = 5'd18
    } t_step;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_START = 3'd1,
        K_WRITE = 3'd2,
        K_READ  = 3'd3,
        K_ACK   = 3'd4,
        K_STOP  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_NOACK  = 2'd1,
        STS_REJECT = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic CFG_PHASE_LEN = 1'b0;
    localparam logic CFG_RETRY     = 1'b1;

    localparam logic [9:0] PHASE_LEN_RST = 10'd100;
    localparam logic [2:0] RETRY_RST     = 3'd5;

    // control code pieces
    localparam logic [7:0] CTRL1_CODE = 8'h0a;
    localparam logic [7:0] CTRL2_CODE = 8'h04;

    // start and stop pin patterns, bit i is the level at step i
    localparam logic [7:0] START_SCK = 8'b00110101;
    localparam logic [7:0] START_SDA = 8'b00011111;
    localparam logic [7:0] STOP_SCK  = 8'b11010110;
    localparam logic [7:0] STOP_SDA  = 8'b11111100;
    localparam logic [3:0] EDGE_LAST = 4'd6;

    // sequencer state carried between ticks
    typedef struct packed {
        t_step       step;
        logic [3:0]  bit_cnt;
        logic [9:0]  timer;
        logic        half_high;
        logic [2:0]  retry;
        logic        is_read;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic [15:0] rshift;
        logic [15:0] rd_result;
    } t_seq_state;

    // per-tick result
    typedef struct packed {
        logic        sck_level;
        logic        sck_drive;
        logic        sda_level;
        logic        sda_drive;
        logic        busy;
        logic        done;
        t_status     status;
        logic [15:0] read_data;
    } t_result;

    function automatic t_kind seg_kind(input t_step s);
        t_kind k;
        unique case (s)
            ST_START:                               k = K_START;
            ST_STOP:                                k = K_STOP;
            ST_RLO, ST_RHI:                         k = K_READ;
            ST_ACKA, ST_ACKB, ST_ACKC, ST_ACKD,
            ST_ACKE:                                k = K_ACK;
            ST_IDLE:                                k = K_NONE;
            default:                                k = K_WRITE;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] seg_bits(input t_step s);
        logic [3:0] n;
        unique case (s)
            ST_CTRL1: n = 4'd4;
            ST_CTRL2: n = 4'd3;
            ST_ALO, ST_AHI, ST_DLO, ST_DHI, ST_RLO, ST_RHI: n = 4'd8;
            default:  n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/smi_seq.sv]
`default_nettype none

module smi_seq (
    input  smi_pkg::t_seq_state i_state,
    input  logic [9:0]          i_phase_len,
    input  logic [2:0]          i_retry_limit,
    input  logic [1:0]          i_opcode,
    input  logic [15:0]         i_reg_addr,
    input  logic [15:0]         i_write_data,
    input  logic                i_sda_in,
    output smi_pkg::t_seq_state o_state,
    output smi_pkg::t_result    o_result
);
    import smi_pkg::*;

    t_seq_state n_st;
    t_kind      cur_kind;
    t_kind      nxt_kind;
    logic [3:0] cur_bits;
    logic [3:0] nxt_bits;
    logic [3:0] bc_inc;
    logic [3:0] shamt;
    logic [7:0] seg_val;
    logic       cmd;
    logic       done;
    logic       fail;
    logic       phase_end;
    t_step      follow;
    t_status    sts;

    assign cmd       = (i_opcode == OP_READ) || (i_opcode == OP_WRITE);
    assign cur_kind  = seg_kind(i_state.step);
    assign cur_bits  = seg_bits(i_state.step);
    assign bc_inc    = i_state.bit_cnt + 4'd1;
    assign phase_end = !(({1'b0, i_state.timer} + 11'd1) < {1'b0, i_phase_len});

    // segment that follows the current one
    always_comb begin
        unique case (i_state.step)
            ST_ACKC:           follow = i_state.is_read ? ST_RLO : ST_DLO;
            ST_ACKE, ST_MNACK: follow = ST_STOP;
            ST_STOP:           follow = ST_IDLE;
            default:           follow = t_step'(i_state.step + 5'd1);
        endcase
    end

    // next sequencer state
    always_comb begin
        n_st = i_state;
        done = 1'b0;
        fail = 1'b0;
        if (i_state.step != ST_IDLE) begin
            if (!phase_end) begin
                n_st.timer = i_state.timer + 10'd1;
            end else begin
                n_st.timer = '0;
                if (cur_kind == K_START || cur_kind == K_STOP) begin
                    if (i_state.bit_cnt >= EDGE_LAST) begin
                        n_st.bit_cnt = '0;
                        n_st.half_high = 1'b0;
                        if (cur_kind == K_START) begin
                            n_st.step = ST_CTRL1;
                        end else begin
                            n_st.step = ST_IDLE;
                            done = 1'b1;
                            if (i_state.is_read) begin
                                n_st.rd_result = i_state.rshift;
                            end
                        end
                    end else begin
                        n_st.bit_cnt = bc_inc;
                    end
                end else if (!i_state.half_high) begin
                    n_st.half_high = 1'b1;
                end else begin
                    n_st.half_high = 1'b0;
                    if (cur_kind == K_ACK) begin
                        if (!i_sda_in) begin
                            n_st.retry = '0;
                            n_st.step = follow;
                            n_st.bit_cnt = '0;
                        end else if (i_state.retry >= i_retry_limit) begin
                            n_st.retry = '0;
                            n_st.step = ST_IDLE;
                            n_st.bit_cnt = '0;
                            done = 1'b1;
                            fail = 1'b1;
                        end else begin
                            n_st.retry = i_state.retry + 3'd1;
                        end
                    end else begin
                        // shift in received bit
                        if (i_state.step == ST_RHI) begin
                            n_st.rshift[15:8] = {i_state.rshift[14:8], i_sda_in};
                        end else if (i_state.step == ST_RLO) begin
                            n_st.rshift[7:0] = {i_state.rshift[6:0], i_sda_in};
                        end
                        if (bc_inc >= cur_bits) begin
                            n_st.step = follow;
                            n_st.bit_cnt = '0;
                        end else begin
                            n_st.bit_cnt = bc_inc;
                        end
                    end
                end
            end
        end else if (cmd) begin
            // latch a new request
            n_st.addr      = i_reg_addr;
            n_st.wdata     = i_write_data;
            n_st.is_read   = (i_opcode == OP_READ);
            n_st.retry     = '0;
            n_st.rshift    = '0;
            n_st.step      = ST_START;
            n_st.bit_cnt   = '0;
            n_st.half_high = 1'b0;
            n_st.timer     = '0;
        end
    end

    // status of this tick
    always_comb begin
        sts = STS_OK;
        if (i_state.step != ST_IDLE && cmd) begin
            sts = STS_REJECT;
        end
        if (done) begin
            sts = fail ? STS_NOACK : STS_OK;
        end
    end

    // data bit of the segment being written
    assign nxt_kind = seg_kind(n_st.step);
    assign nxt_bits = seg_bits(n_st.step);
    assign shamt    = (n_st.bit_cnt < nxt_bits) ? (nxt_bits - 4'd1 - n_st.bit_cnt) : 4'd0;

    always_comb begin
        unique case (n_st.step)
            ST_CTRL1: seg_val = CTRL1_CODE;
            ST_CTRL2: seg_val = CTRL2_CODE;
            ST_RW:    seg_val = {7'd0, n_st.is_read};
            ST_ALO:   seg_val = n_st.addr[7:0];
            ST_AHI:   seg_val = n_st.addr[15:8];
            ST_DLO:   seg_val = n_st.wdata[7:0];
            ST_DHI:   seg_val = n_st.wdata[15:8];
            ST_MNACK: seg_val = 8'd1;
            default:  seg_val = 8'd0;
        endcase
    end

    // pin levels after this tick
    always_comb begin
        o_result           = '0;
        o_result.sck_level = 1'b1;
        o_result.sda_level = 1'b1;
        o_result.busy      = (n_st.step != ST_IDLE);
        o_result.done      = done;
        o_result.status    = sts;
        o_result.read_data = n_st.rd_result;
        if (n_st.step != ST_IDLE) begin
            o_result.sck_drive = 1'b1;
            unique case (nxt_kind)
                K_START: begin
                    o_result.sck_level = START_SCK[n_st.bit_cnt[2:0]];
                    o_result.sda_level = START_SDA[n_st.bit_cnt[2:0]];
                    o_result.sda_drive = 1'b1;
                end
                K_STOP: begin
                    o_result.sck_level = STOP_SCK[n_st.bit_cnt[2:0]];
                    o_result.sda_level = STOP_SDA[n_st.bit_cnt[2:0]];
                    o_result.sda_drive = 1'b1;
                end
                K_WRITE: begin
                    o_result.sck_level = n_st.half_high;
                    o_result.sda_level = seg_val[shamt[2:0]];
                    o_result.sda_drive = 1'b1;
                end
                default: begin
                    o_result.sck_level = n_st.half_high;
                end
            endcase
        end
    end

    assign o_state = n_st;

endmodule

`default_nettype wire

[rtl/smi_two_wire_register_master_unit.sv]
`default_nettype none

// channel   dir  fields (lowest bit up)
// s_axis    in   tuser: opcode[1:0]
//                tdata: reg_addr[15:0], write_data[31:16], sda_in[32], zero pad
// m_axis    out  tdata: sck_level, sck_drive, sda_level, sda_drive, busy_res,
//                       done_res, status[7:6], read_data[23:8]
// cfg       in   i_cfg_we, i_cfg_idx (0 phase_length, 1 ack_retry_limit), i_cfg_data
//
// one tick request per cycle while s_axis_tready is high; its result is registered
// the sequencer state and the output register are updated in the same edge
// s_axis_tready drops only while a result waits and m_axis_tready is low
// synchronous active-low reset returns the sequencer to idle and clears m_axis_tvalid

module smi_two_wire_register_master_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // reg_addr, write_data, sda_in
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // pins, busy_res, done_res, status, read_data
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [9:0]  i_cfg_data
);
    import smi_pkg::*;

    t_seq_state r_state;
    t_seq_state n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_m_valid;
    logic [9:0] r_phase_len;
    logic [2:0] r_retry_limit;
    logic       accept;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_len   <= PHASE_LEN_RST;
            r_retry_limit <= RETRY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PHASE_LEN) begin
                r_phase_len <= i_cfg_data;
            end else begin
                r_retry_limit <= i_cfg_data[2:0];
            end
        end
    end

    smi_seq u_seq (
        .i_state       (r_state),
        .i_phase_len   (r_phase_len),
        .i_retry_limit (r_retry_limit),
        .i_opcode      (s_axis_tuser),
        .i_reg_addr    (s_axis_tdata[15:0]),
        .i_write_data  (s_axis_tdata[31:16]),
        .i_sda_in      (s_axis_tdata[32]),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // sequencer state, all zero is idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_result.read_data, r_result.status, r_result.done,
                            r_result.busy, r_result.sda_drive, r_result.sda_level,
                            r_result.sck_drive, r_result.sck_level};

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && r_result.done |-> !r_result.busy)
        else $error("transfer end reported while still busy");

    a_noack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && (r_result.status == STS_NOACK) |-> r_result.done)
        else $error("no-acknowledge status without end pulse");

    a_idle_retry_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.step == ST_IDLE) |-> (r_state.retry == 3'd0))
        else $error("retry count left over in idle");

    a_edge_no_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.step == ST_START || r_state.step == ST_STOP) |-> !r_state.half_high)
        else $error("half flag set during start or stop");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_m_valid)
        else $error("accepted tick produced no result");
`endif

endmodule

`default_nettype wire
